// ----- rtl/core/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and constants for the sorted priority queue
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int KEY_W   = 32;
    localparam int TAG_W   = 16;
    localparam int COUNT_W = 5;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [TAG_W-1:0]        t_tag;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
        t_key key;
        t_tag tag;
    } t_in;

    typedef struct packed {
        t_key               top_key;
        t_tag               top_tag;
        logic               is_empty;
        logic [COUNT_W-1:0] entry_count;
        logic               overflow;
    } t_out;

    // broadcast to every cell for one beat
    typedef struct packed {
        logic push;
        logic pop;
        t_key key;
        t_tag tag;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- rtl/core/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds an entry, compares and shifts
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
    input  wire logic              i_clk,
    input  wire spq_pkg::t_cell_ctl i_ctl,
    input  wire logic              i_occ,
    input  wire logic              i_prev_gt,
    input  wire spq_pkg::t_key     i_prev_key,
    input  wire spq_pkg::t_tag     i_prev_tag,
    input  wire spq_pkg::t_key     i_next_key,
    input  wire spq_pkg::t_tag     i_next_tag,
    output      logic              o_gt,
    output      spq_pkg::t_key     o_key,
    output      spq_pkg::t_tag     o_tag,
    output      spq_pkg::t_key     o_nxt_key,
    output      spq_pkg::t_tag     o_nxt_tag
);

    spq_pkg::t_key r_key, n_key;
    spq_pkg::t_tag r_tag, n_tag;
    logic          w_gt;

    // stored entry strictly larger than the pushed one stays put
    assign w_gt = i_occ && (r_key > i_ctl.key);

    always_comb begin
        n_key = r_key;
        n_tag = r_tag;
        if (i_ctl.push) begin
            if (w_gt) begin
                n_key = r_key;
                n_tag = r_tag;
            end else if (i_prev_gt) begin
                n_key = i_ctl.key;
                n_tag = i_ctl.tag;
            end else begin
                n_key = i_prev_key;
                n_tag = i_prev_tag;
            end
        end else if (i_ctl.pop) begin
            n_key = i_next_key;
            n_tag = i_next_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
    end

    assign o_gt      = w_gt;
    assign o_key     = r_key;
    assign o_tag     = r_tag;
    assign o_nxt_key = n_key;
    assign o_nxt_tag = n_tag;

endmodule

`default_nettype wire

// ----- rtl/core/sorted_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// max-first priority queue held as a sorted chain of cells
// ----------------------------------------------------------------------------
// usage
//   input channel : i_valid / i_data / o_stall, one beat is push or pop
//   output channel: o_valid / o_data / i_stall, one result beat per input beat
//   each result gives the head key and tag, empty flag, entry count and a
//   flag set when a push found the queue full and was dropped
//   a result shows on o_valid in the cycle after its input beat is taken
//   throughput: one beat per cycle while o_stall is low; every cell compares
//   its key with the pushed key in parallel and all cells shift together,
//   so the chain itself never holds up a beat
//   equal keys leave newest first; a pop on an empty queue changes nothing
//   reset clears the entry count and the result valid flag; cell contents
//   are left as they are and are never read until written
//   while the receiver stalls a waiting result, the result register holds and o_stall goes
//   high, so input is taken again in the same cycle the result leaves
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_unit #(
    parameter int DEPTH = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire spq_pkg::t_in   i_data,
    output      logic           o_stall,
    output      logic           o_valid,
    output      spq_pkg::t_out  o_data,
    input  wire logic           i_stall
);

    localparam int CW = $clog2(DEPTH + 1);

    // entry count and its next value
    logic [CW-1:0]      r_count, n_count;
    logic               r_out_valid;
    spq_pkg::t_out      r_out, n_out;

    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    spq_pkg::t_cell_ctl w_ctl;
    logic [CW+4:0]      w_count_ext;

    // chain taps
    logic               w_gt  [DEPTH];
    spq_pkg::t_key      w_key [DEPTH];
    spq_pkg::t_tag      w_tag [DEPTH];
    spq_pkg::t_key      w_nkey[DEPTH];
    spq_pkg::t_tag      w_ntag[DEPTH];

    // input is blocked only while a finished result waits on a stalled receiver
    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    always_comb begin
        w_ctl.push = w_accept && (i_data.cmd == spq_pkg::CMD_PUSH) && !w_full;
        w_ctl.pop  = w_accept && (i_data.cmd == spq_pkg::CMD_POP) && !w_empty;
        w_ctl.key  = i_data.key;
        w_ctl.tag  = i_data.tag;
    end

    // row of cells, slot 0 is the head
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic          w_occ;
        logic          w_prev_gt;
        spq_pkg::t_key w_prev_key;
        spq_pkg::t_tag w_prev_tag;
        spq_pkg::t_key w_next_key;
        spq_pkg::t_tag w_next_tag;

        assign w_occ = (CW'(g) < r_count);

        if (g == 0) begin : g_head
            assign w_prev_gt  = 1'b1;
            assign w_prev_key = '0;
            assign w_prev_tag = '0;
        end else begin : g_body
            assign w_prev_gt  = w_gt[g-1];
            assign w_prev_key = w_key[g-1];
            assign w_prev_tag = w_tag[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            // tail slot falls out of use on a pop
            assign w_next_key = '0;
            assign w_next_tag = '0;
        end else begin : g_mid
            assign w_next_key = w_key[g+1];
            assign w_next_tag = w_tag[g+1];
        end

        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_occ      (w_occ),
            .i_prev_gt  (w_prev_gt),
            .i_prev_key (w_prev_key),
            .i_prev_tag (w_prev_tag),
            .i_next_key (w_next_key),
            .i_next_tag (w_next_tag),
            .o_gt       (w_gt[g]),
            .o_key      (w_key[g]),
            .o_tag      (w_tag[g]),
            .o_nxt_key  (w_nkey[g]),
            .o_nxt_tag  (w_ntag[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.push) begin
            n_count = r_count + CW'(1);
        end else if (w_ctl.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    // count reported modulo the field width
    assign w_count_ext = {5'd0, n_count};

    // result describes the queue after this beat
    always_comb begin
        n_out.top_key     = (n_count != '0) ? w_nkey[0] : '0;
        n_out.top_tag     = (n_count != '0) ? w_ntag[0] : '0;
        n_out.is_empty    = (n_count == '0);
        n_out.entry_count = w_count_ext[spq_pkg::COUNT_W-1:0];
        n_out.overflow    = w_accept && (i_data.cmd == spq_pkg::CMD_PUSH) && w_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // count never runs past the number of cells
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    // a waiting result agrees with the live count on emptiness
    a_empty_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.is_empty == (r_count == '0)))
        else $error("empty flag disagrees with entry count");

    // a push taken while full comes back flagged
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_data.cmd == spq_pkg::CMD_PUSH) && w_full)
            |=> (o_valid && o_data.overflow))
        else $error("dropped push not flagged");

    // head is never smaller than the second slot
    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> (w_key[0] >= w_key[1]))
        else $error("head out of order");

endmodule

`default_nettype wire
